// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define C3S_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c3s assertion failed");

// Next-cycle implication, off while reset is high.
`define C3S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c3s assertion failed");

`endif

// ===== rtl/c3s_pkg.sv =====
// Package: constants, register codes and shared types of the 3x3 convolution block.
`default_nettype none

package c3s_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int TAPS       = 9;
   localparam int RESP_W     = 20;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic [CSR_DATA_W-1:0] COEF_TOP_RST = 24'h0100FF;
   localparam logic [CSR_DATA_W-1:0] COEF_MID_RST = 24'h0200FE;
   localparam logic [CSR_DATA_W-1:0] COEF_BOT_RST = 24'h0100FF;
   localparam logic [WIDTH_W-1:0]    WIDTH_RST    = 11'd640;
   localparam logic [HEIGHT_W-1:0]   HEIGHT_RST   = 12'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP = 3'd0,
      CSR_COEF_MID = 3'd1,
      CSR_COEF_BOT = 3'd2,
      CSR_WIDTH    = 3'd3,
      CSR_HEIGHT   = 3'd4
   } csr_idx_type;

   // position of the current item and what it yields
   typedef struct packed {
      logic             has_result;
      logic             frame_last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

   // one line buffer entry: the two rows above the incoming pixel
   typedef struct packed {
      logic [PIX_W-1:0] newer;
      logic [PIX_W-1:0] older;
   } line_type;

endpackage

`default_nettype wire

// ===== rtl/conv3x3_stream.sv =====
// Top level: streaming 3x3 correlation over a raster pixel stream.
//
// req_ carries one 8-bit grayscale pixel per item in raster order from frame
// start. rsp_ carries one item per interior pixel: the signed 20-bit window
// sum, its row and column, and tlast on the last interior pixel of the frame.
// Border pixels give no item. The item for pixel (r,c) is formed once pixel
// (r+1,c+1) has been taken.
// Throughput: one pixel per cycle while rsp_tready stays high; a single
// line buffer memory (one read and one write per cycle) and a three-stage
// pipeline (input/read register, window, output register) set that figure.
// When rsp_tready is low the output register holds its item and the stages
// behind it fill; req_tready drops once the input stage can no longer move.
// Reset empties the pipeline, zeroes the scan position and window, loads the
// Sobel-x mask and a 640x480 frame size. The line buffer is not cleared.
// csr_ writes are registered; write only while the block is idle.
`default_nettype none

module conv3x3_stream (
   input  wire                               clock,
   input  wire                               reset,
   // slave side: [7:0] pixel
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [c3s_pkg::PIX_W-1:0]         req_tdata,
   // master side: [19:0] response, [31:20] out_row, [41:32] out_col, zero fill
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [c3s_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,   // frame_last
   input  wire                               csr_we,
   input  wire  [c3s_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [c3s_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FILL_W = c3s_pkg::RSP_DATA_W - c3s_pkg::RESP_W
                         - c3s_pkg::ROW_W - c3s_pkg::COL_W;

   // configuration registers
   logic [c3s_pkg::CSR_DATA_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [c3s_pkg::WIDTH_W-1:0]    width_ff;
   logic [c3s_pkg::HEIGHT_W-1:0]   height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= c3s_pkg::COEF_TOP_RST;
         coef_mid_ff <= c3s_pkg::COEF_MID_RST;
         coef_bot_ff <= c3s_pkg::COEF_BOT_RST;
         width_ff    <= c3s_pkg::WIDTH_RST;
         height_ff   <= c3s_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            c3s_pkg::CSR_COEF_TOP: coef_top_ff <= csr_wdata;
            c3s_pkg::CSR_COEF_MID: coef_mid_ff <= csr_wdata;
            c3s_pkg::CSR_COEF_BOT: coef_bot_ff <= csr_wdata;
            c3s_pkg::CSR_WIDTH:    width_ff    <= csr_wdata[c3s_pkg::WIDTH_W-1:0];
            c3s_pkg::CSR_HEIGHT:   height_ff   <= csr_wdata[c3s_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic accept, a_fire, b_fire, a_free, b_free, out_free;
   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in, rsp_valid_ff, rsp_valid_in;

   c3s_pkg::pos_type              scan_pos, a_pos_ff, b_pos_ff;
   logic [c3s_pkg::ADDR_W-1:0]    scan_addr, a_addr_ff;
   logic [c3s_pkg::PIX_W-1:0]     a_pix_ff;
   c3s_pkg::line_type             line_rd, line_wr;
   logic signed [c3s_pkg::RESP_W-1:0] win_sum;

   logic signed [c3s_pkg::RESP_W-1:0] rsp_resp_ff;
   logic [c3s_pkg::ROW_W-1:0]         rsp_row_ff;
   logic [c3s_pkg::COL_W-1:0]         rsp_col_ff;
   logic                              rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign b_fire   = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;
   // the window only moves when stage B is free, so B always sees its own window
   assign a_fire   = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || a_fire;
   assign accept   = req_tvalid && a_free;

   always_comb begin
      a_valid_in = accept ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);
      b_valid_in = a_fire ? a_pos_ff.has_result : (b_fire ? 1'b0 : b_valid_ff);
      rsp_valid_in = b_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff  <= req_tdata;
         a_pos_ff  <= scan_pos;
         a_addr_ff <= scan_addr;
      end
      if (a_fire) begin
         b_pos_ff <= a_pos_ff;
      end
      if (b_fire) begin
         rsp_resp_ff <= win_sum;
         rsp_row_ff  <= b_pos_ff.row;
         rsp_col_ff  <= b_pos_ff.col;
         rsp_last_ff <= b_pos_ff.frame_last;
      end
   end

   c3s_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .col_addr     (scan_addr),
      .pos          (scan_pos)
   );

   // rows move up by one as the new pixel is written back
   assign line_wr.older = line_rd.newer;
   assign line_wr.newer = a_pix_ff;

   c3s_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (scan_addr),
      .rd_data (line_rd),
      .wr_en   (a_fire),
      .wr_addr (a_addr_ff),
      .wr_data (line_wr)
   );

   c3s_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .shift_en (a_fire),
      .pix_top  (line_rd.older),
      .pix_mid  (line_rd.newer),
      .pix_bot  (a_pix_ff),
      .coefs    ({coef_bot_ff, coef_mid_ff, coef_top_ff}),
      .sum      (win_sum)
   );

   assign req_tready = a_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{FILL_W{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_resp_ff};

endmodule

`default_nettype wire

// ===== rtl/c3s_linebuf.sv =====
// Line buffer: one memory holding the previous two image rows per column.
`default_nettype none

module c3s_linebuf (
   input  wire                         clock,
   input  wire                         rd_en,
   input  wire  [c3s_pkg::ADDR_W-1:0]  rd_addr,
   output c3s_pkg::line_type           rd_data,
   input  wire                         wr_en,
   input  wire  [c3s_pkg::ADDR_W-1:0]  wr_addr,
   input  c3s_pkg::line_type           wr_data
);

   c3s_pkg::line_type mem [c3s_pkg::MAX_WIDTH];
   c3s_pkg::line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/c3s_scan.sv =====
// Raster scan counters: column/row position, border and end-of-frame detection.
`default_nettype none

module c3s_scan (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire  [c3s_pkg::WIDTH_W-1:0]   image_width,
   input  wire  [c3s_pkg::HEIGHT_W-1:0]  image_height,
   output logic [c3s_pkg::ADDR_W-1:0]    col_addr,
   output c3s_pkg::pos_type              pos
);

   logic [c3s_pkg::COL_W-1:0]    col_ff, col_in;
   logic [c3s_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [c3s_pkg::WIDTH_W-1:0]  width_eff, width_m1;
   logic [c3s_pkg::HEIGHT_W-1:0] height_eff, height_m1;
   logic                         row_end, frame_end;

   // width saturates to 3..MAX_WIDTH, height to at least 3
   always_comb begin
      if (image_width < c3s_pkg::WIDTH_W'(3)) begin
         width_eff = c3s_pkg::WIDTH_W'(3);
      end else if (image_width > c3s_pkg::WIDTH_W'(c3s_pkg::MAX_WIDTH)) begin
         width_eff = c3s_pkg::WIDTH_W'(c3s_pkg::MAX_WIDTH);
      end else begin
         width_eff = image_width;
      end
      if (image_height < c3s_pkg::HEIGHT_W'(3)) begin
         height_eff = c3s_pkg::HEIGHT_W'(3);
      end else begin
         height_eff = image_height;
      end
   end

   assign width_m1  = width_eff - c3s_pkg::WIDTH_W'(1);
   assign height_m1 = height_eff - c3s_pkg::HEIGHT_W'(1);

   // >= so that a size change between frames still ends the row/frame
   assign row_end   = c3s_pkg::WIDTH_W'(col_ff) >= width_m1;
   assign frame_end = row_end && (row_ff >= height_m1);

   always_comb begin
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + c3s_pkg::ROW_W'(1);
      end else begin
         col_in = col_ff + c3s_pkg::COL_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col_addr       = col_ff[c3s_pkg::ADDR_W-1:0];
   assign pos.has_result = (row_ff >= c3s_pkg::ROW_W'(2)) && (col_ff >= c3s_pkg::COL_W'(2));
   assign pos.frame_last = frame_end;
   assign pos.row        = row_ff - c3s_pkg::ROW_W'(1);
   assign pos.col        = col_ff - c3s_pkg::COL_W'(1);

endmodule

`default_nettype wire

// ===== rtl/c3s_mac.sv =====
// 3x3 window register and the weighted sum of its nine pixels.
`default_nettype none

module c3s_mac (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      shift_en,
   input  wire  [c3s_pkg::PIX_W-1:0]                pix_top,
   input  wire  [c3s_pkg::PIX_W-1:0]                pix_mid,
   input  wire  [c3s_pkg::PIX_W-1:0]                pix_bot,
   input  wire  [c3s_pkg::TAPS*c3s_pkg::COEF_W-1:0] coefs,
   output logic signed [c3s_pkg::RESP_W-1:0]        sum
);

   localparam int PROD_W = c3s_pkg::COEF_W + c3s_pkg::PIX_W + 1;

   // index 3*row + column, column 2 newest
   logic [c3s_pkg::PIX_W-1:0]         win_ff [c3s_pkg::TAPS];
   logic signed [PROD_W-1:0]          prod   [c3s_pkg::TAPS];
   logic signed [c3s_pkg::RESP_W-1:0] term   [c3s_pkg::TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < c3s_pkg::TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[3*r]   <= win_ff[3*r+1];
            win_ff[3*r+1] <= win_ff[3*r+2];
         end
         win_ff[2] <= pix_top;
         win_ff[5] <= pix_mid;
         win_ff[8] <= pix_bot;
      end
   end

   always_comb begin
      for (int i = 0; i < c3s_pkg::TAPS; i++) begin
         prod[i] = $signed(coefs[c3s_pkg::COEF_W*i +: c3s_pkg::COEF_W])
                 * $signed({1'b0, win_ff[i]});
         term[i] = c3s_pkg::RESP_W'(prod[i]);
      end
   end

   assign sum = ((term[0] + term[1]) + (term[2] + term[3]))
              + ((term[4] + term[5]) + (term[6] + term[7])) + term[8];

endmodule

`default_nettype wire

// ===== rtl/c3s_checker.sv =====
// Port-level checker for the 3x3 convolution block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module c3s_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [c3s_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                            rsp_tlast
);

   logic                          rsp_stall;
   logic [c3s_pkg::RSP_DATA_W:0]  rsp_item;
   logic [c3s_pkg::ROW_W-1:0]     rsp_row;
   logic [c3s_pkg::COL_W-1:0]     rsp_col;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_item  = {rsp_tlast, rsp_tdata};
   assign rsp_row   = rsp_tdata[c3s_pkg::RESP_W +: c3s_pkg::ROW_W];
   assign rsp_col   = rsp_tdata[c3s_pkg::RESP_W + c3s_pkg::ROW_W +: c3s_pkg::COL_W];

   // a stalled result holds
   `C3S_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_item))

   // results only for interior pixels: row and column never zero
   `C3S_ASSERT_SAME(a_interior, clock, reset, rsp_tvalid, (rsp_row != '0) && (rsp_col != '0))

   // reset leaves no result pending
   `C3S_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind conv3x3_stream c3s_checker u_c3s_checker (.*);

`default_nettype wire
